// ===== hw/rtl/kns_pkg.sv =====
// Shared types and constants of the k-nearest point selection block.
package kns_pkg;

  localparam int POINT_CAPACITY_DEF = 256;
  localparam int TARGET_LIMIT_DEF   = 16;
  localparam int COORD_BITS_DEF     = 24;

  localparam int COORD_FIELD_W = 24;
  localparam int INDEX_FIELD_W = 8;
  localparam int DIST_FIELD_W  = 50;
  localparam int CFG_W         = 5;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic {
    CMD_ORIGIN = 1'b0,
    CMD_POINT  = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    last;
  } cmd_ctl_t;

endpackage

// ===== hw/rtl/k_nearest_point_select.sv =====
// Top level of the k-nearest point selection block.
//
// Words enter through a four-word command queue and are taken whenever busy is low, one per
// cycle, also while a selection runs; busy rises only when that queue is full. The back end
// drains the queue at one word per cycle while it loads points. A point word that carries the
// last mark starts a selection unless the target count is zero: a distance pass reads the point
// memory once through its three-stage difference, square and sum pipeline. If no more points
// are stored than the target count, the results then follow one per cycle in load order.
// Otherwise each result is one scan over the distance memory. Each result appears on the
// out_ ports for one cycle with out_valid high and must be taken then. The max_targets register
// is written through cfg_we and cfg_wdata; the user must write it only while idle, as the
// block itself does not enforce this.
module k_nearest_point_select import kns_pkg::*; #(
  parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
  parameter int TARGET_LIMIT   = TARGET_LIMIT_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic signed [COORD_FIELD_W-1:0] in_coord_x,
  input  logic signed [COORD_FIELD_W-1:0] in_coord_y,
  input  logic signed [COORD_FIELD_W-1:0] in_coord_z,
  input  logic                            in_last_point,
  output logic                            out_valid,
  output logic [INDEX_FIELD_W-1:0]        out_target_index,
  output logic [DIST_FIELD_W-1:0]         out_distance_sq,
  output logic                            out_end_of_run,
  output logic                            out_overflow,
  input  logic                            cfg_we,
  input  logic [CFG_W-1:0]                cfg_wdata
);

  logic                    q_valid;
  cmd_ctl_t                q_ctl;
  logic [3*COORD_BITS-1:0] q_coords;
  logic                    q_pop;

  kns_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_last_point (in_last_point),
    .q_valid       (q_valid),
    .q_ctl         (q_ctl),
    .q_coords      (q_coords),
    .q_pop         (q_pop)
  );

  kns_back #(
    .POINT_CAPACITY (POINT_CAPACITY),
    .TARGET_LIMIT   (TARGET_LIMIT),
    .COORD_BITS     (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ctl            (q_ctl),
    .q_coords         (q_coords),
    .q_pop            (q_pop),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_target_index (out_target_index),
    .out_distance_sq  (out_distance_sq),
    .out_end_of_run   (out_end_of_run),
    .out_overflow     (out_overflow)
  );

endmodule

// ===== hw/rtl/kns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module kns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kns_front.sv =====
// Front end: accepts input words, classifies them and queues them as commands.
module kns_front import kns_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_kind,
  input  logic signed [COORD_FIELD_W-1:0]  in_coord_x,
  input  logic signed [COORD_FIELD_W-1:0]  in_coord_y,
  input  logic signed [COORD_FIELD_W-1:0]  in_coord_z,
  input  logic                             in_last_point,
  output logic                             q_valid,
  output cmd_ctl_t                         q_ctl,
  output logic [3*COORD_BITS-1:0]          q_coords,
  input  logic                             q_pop
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_ctl_t                ctl_mem [QUEUE_DEPTH];
  logic [3*COORD_BITS-1:0] crd_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r;
  logic [PTR_W-1:0]        rd_ptr_r;
  logic [FILL_W-1:0]       fill_r;
  logic                    push;
  logic                    pop;
  cmd_ctl_t                ctl_in;
  logic [3*COORD_BITS-1:0] crd_in;

  assign busy    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign q_valid = (fill_r != '0);
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_comb begin
    ctl_in.op   = in_kind ? CMD_POINT : CMD_ORIGIN;
    ctl_in.last = in_kind & in_last_point;
    crd_in      = {COORD_BITS'(in_coord_z), COORD_BITS'(in_coord_y),
                   COORD_BITS'(in_coord_x)};
  end

  assign q_ctl    = ctl_mem[rd_ptr_r];
  assign q_coords = crd_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr_r] <= ctl_in;
      crd_mem[wr_ptr_r] <= crd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/kns_back.sv =====
// Back end: stores points, computes distances and runs the nearest-point selection.
module kns_back import kns_pkg::*; #(
  parameter int POINT_CAPACITY = POINT_CAPACITY_DEF,
  parameter int TARGET_LIMIT   = TARGET_LIMIT_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  cmd_ctl_t                  q_ctl,
  input  logic [3*COORD_BITS-1:0]   q_coords,
  output logic                      q_pop,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_wdata,
  output logic                      out_valid,
  output logic [INDEX_FIELD_W-1:0]  out_target_index,
  output logic [DIST_FIELD_W-1:0]   out_distance_sq,
  output logic                      out_end_of_run,
  output logic                      out_overflow
);

  localparam int CB     = COORD_BITS;
  localparam int PW     = 3 * CB;
  localparam int IDX_W  = $clog2(POINT_CAPACITY);
  localparam int CNT_W  = $clog2(POINT_CAPACITY + 1);
  localparam int TGT_W  = $clog2(TARGET_LIMIT + 1);
  localparam int DSUM_W = 2 * CB + 2;
  localparam int DREC_W = DSUM_W + 1;
  localparam int WCMP_W = (CFG_W > TGT_W) ? CFG_W : TGT_W;
  localparam int NCMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int OCMP_W = (DSUM_W > DIST_FIELD_W) ? DSUM_W : DIST_FIELD_W;
  localparam logic [DIST_FIELD_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIST,
    ST_LIST,
    ST_SCAN
  } state_t;

  state_t              state_r;
  logic [PW-1:0]       origin_r;
  logic [CNT_W-1:0]    count_r;
  logic                dropped_r;
  logic [CFG_W-1:0]    max_targets_r;
  logic [TGT_W-1:0]    want_r;
  logic [TGT_W-1:0]    k_r;
  logic [CNT_W-1:0]    scan_r;
  logic                rv_r;
  logic                rlast_r;
  logic [IDX_W-1:0]    ridx_r;
  logic                v1_r;
  logic [IDX_W-1:0]    idx1_r;
  logic                v2_r;
  logic [IDX_W-1:0]    idx2_r;
  logic [CB-1:0]       ad_r [3];
  logic [2*CB-1:0]     sq_r [3];
  logic                found_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [DSUM_W-1:0]   best_d_r;

  logic                out_valid_r;
  logic [INDEX_FIELD_W-1:0] out_idx_r;
  logic [DIST_FIELD_W-1:0]  out_dist_r;
  logic                out_end_r;
  logic                out_ovf_r;

  logic                pop_ok;
  logic                has_room;
  logic [CNT_W-1:0]    count_inc;
  logic [TGT_W-1:0]    want_nxt;
  logic                scanning;
  logic [IDX_W-1:0]    rd_addr;
  logic                last_rd;
  logic                pipe_empty;
  logic                st_we;
  logic [PW-1:0]       st_rdata;
  logic                drec_we;
  logic [IDX_W-1:0]    drec_waddr;
  logic [DREC_W-1:0]   drec_wdata;
  logic [DREC_W-1:0]   drec_rdata;
  logic                drec_taken;
  logic [DSUM_W-1:0]   drec_dist;
  logic                cand;
  logic [IDX_W-1:0]    fin_idx;
  logic [DSUM_W-1:0]   fin_d;
  logic [DSUM_W-1:0]   sum;
  logic [DSUM_W-1:0]   emit_d;
  logic [DIST_FIELD_W-1:0] emit_sat;
  logic [CB-1:0]       ad_nxt [3];
  logic                run_end;

  assign q_pop     = (state_r == ST_RUN);
  assign pop_ok    = q_pop && q_valid;
  assign has_room  = (count_r < CNT_W'(POINT_CAPACITY));
  assign count_inc = has_room ? count_r + 1'b1 : count_r;
  assign want_nxt  = TGT_W'((WCMP_W'(max_targets_r) < WCMP_W'(TARGET_LIMIT)) ?
                            WCMP_W'(max_targets_r) : WCMP_W'(TARGET_LIMIT));
  assign st_we     = pop_ok && (q_ctl.op == CMD_POINT) && has_room;

  assign scanning   = (state_r != ST_RUN) && (scan_r < count_r);
  assign rd_addr    = scan_r[IDX_W-1:0];
  assign last_rd    = (scan_r == count_r - CNT_W'(1));
  assign pipe_empty = !rv_r && !v1_r && !v2_r;

  assign drec_taken = drec_rdata[DSUM_W];
  assign drec_dist  = drec_rdata[DSUM_W-1:0];
  assign cand       = rv_r && !drec_taken && (!found_r || (drec_dist < best_d_r));
  assign fin_idx    = cand ? ridx_r : best_idx_r;
  assign fin_d      = cand ? drec_dist : best_d_r;
  assign run_end    = (k_r == want_r - TGT_W'(1));

  assign sum = DSUM_W'(sq_r[0]) + DSUM_W'(sq_r[1]) + DSUM_W'(sq_r[2]);

  assign drec_we    = v2_r || ((state_r == ST_SCAN) && rv_r && rlast_r);
  assign drec_waddr = v2_r ? idx2_r : fin_idx;
  assign drec_wdata = v2_r ? {1'b0, sum} : {1'b1, fin_d};

  assign emit_d   = (state_r == ST_LIST) ? drec_dist : fin_d;
  assign emit_sat = (OCMP_W'(emit_d) > OCMP_W'(DIST_MAX)) ? DIST_MAX :
                    DIST_FIELD_W'(OCMP_W'(emit_d));

  always_comb begin
    logic signed [CB:0] d;
    for (int a = 0; a < 3; a++) begin
      d = (CB+1)'(signed'(st_rdata[a*CB +: CB])) -
          (CB+1)'(signed'(origin_r[a*CB +: CB]));
      ad_nxt[a] = d[CB] ? CB'(-d) : CB'(d);
    end
  end

  kns_ram #(
    .WIDTH (PW),
    .DEPTH (POINT_CAPACITY)
  ) u_point_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (q_coords),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  kns_ram #(
    .WIDTH (DREC_W),
    .DEPTH (POINT_CAPACITY)
  ) u_dist_ram (
    .clk   (clk),
    .we    (drec_we),
    .waddr (drec_waddr),
    .wdata (drec_wdata),
    .raddr (rd_addr),
    .rdata (drec_rdata)
  );

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      ad_r[a] <= ad_nxt[a];
      sq_r[a] <= (2*CB)'(ad_r[a]) * (2*CB)'(ad_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_RUN;
      origin_r      <= '0;
      count_r       <= '0;
      dropped_r     <= 1'b0;
      max_targets_r <= CFG_W'(1);
      want_r        <= '0;
      k_r           <= '0;
      scan_r        <= '0;
      rv_r          <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_targets_r <= cfg_wdata;
      end
      out_valid_r <= rv_r && ((state_r == ST_LIST) || ((state_r == ST_SCAN) && rlast_r));
      rv_r        <= scanning;
      ridx_r      <= rd_addr;
      rlast_r     <= last_rd;
      v1_r        <= rv_r && (state_r == ST_DIST);
      idx1_r      <= ridx_r;
      v2_r        <= v1_r;
      idx2_r      <= idx1_r;
      if (scanning) begin
        scan_r <= scan_r + 1'b1;
      end
      case (state_r)
        ST_RUN: begin
          if (pop_ok) begin
            if (q_ctl.op == CMD_ORIGIN) begin
              origin_r <= q_coords;
            end else begin
              if (q_ctl.last && (want_nxt == '0)) begin
                count_r   <= '0;
                dropped_r <= 1'b0;
              end else begin
                count_r <= count_inc;
                if (!has_room) begin
                  dropped_r <= 1'b1;
                end
              end
              if (q_ctl.last) begin
                want_r <= want_nxt;
                if (want_nxt != '0) begin
                  scan_r  <= '0;
                  state_r <= ST_DIST;
                end
              end
            end
          end
        end
        ST_DIST: begin
          if ((scan_r == count_r) && pipe_empty) begin
            scan_r  <= '0;
            found_r <= 1'b0;
            k_r     <= '0;
            state_r <= (NCMP_W'(count_r) <= NCMP_W'(want_r)) ? ST_LIST : ST_SCAN;
          end
        end
        ST_LIST: begin
          if (rv_r) begin
            out_idx_r   <= INDEX_FIELD_W'(ridx_r);
            out_dist_r  <= emit_sat;
            out_end_r   <= rlast_r;
            out_ovf_r   <= dropped_r;
            if (rlast_r) begin
              count_r   <= '0;
              dropped_r <= 1'b0;
              state_r   <= ST_RUN;
            end
          end
        end
        ST_SCAN: begin
          if (rv_r) begin
            if (!rlast_r) begin
              if (cand) begin
                found_r    <= 1'b1;
                best_idx_r <= ridx_r;
                best_d_r   <= drec_dist;
              end
            end else begin
              out_idx_r   <= INDEX_FIELD_W'(fin_idx);
              out_dist_r  <= emit_sat;
              out_end_r   <= run_end;
              out_ovf_r   <= dropped_r;
              found_r     <= 1'b0;
              k_r         <= k_r + 1'b1;
              scan_r      <= '0;
              if (run_end) begin
                count_r   <= '0;
                dropped_r <= 1'b0;
                state_r   <= ST_RUN;
              end
            end
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_index = out_idx_r;
  assign out_distance_sq  = out_dist_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ===== hw/rtl/kns_checker.sv =====
// Port-level assertions for the k-nearest point selection block, with its bind.
module kns_checker import kns_pkg::*; (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            busy,
  input logic                            out_valid,
  input logic [INDEX_FIELD_W-1:0]        out_target_index,
  input logic                            out_end_of_run,
  input logic                            out_overflow
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or out_valid set right after reset");

  a_gap_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_run |=> !out_valid)
    else $error("a word followed the end of a run in the next cycle");

  a_back_to_back_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_end_of_run) |->
      out_target_index == $past(out_target_index) + 8'd1)
    else $error("consecutive result words are not in load order");

  a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$past(out_end_of_run) |->
      out_overflow == $past(out_overflow))
    else $error("overflow changed within one run");

endmodule

bind k_nearest_point_select kns_checker u_kns_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the k-nearest point selection block.
module tb_top import kns_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_FIELD_W-1:0] coord_t;

  typedef struct packed {
    logic [INDEX_FIELD_W-1:0] index;
    logic [DIST_FIELD_W-1:0]  dist_sq;
    logic                     end_flag;
    logic                     ovf;
  } pick_t;

  localparam coord_t COORD_MAX = coord_t'((1 << (COORD_FIELD_W - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(-(1 << (COORD_FIELD_W - 1)));
  localparam longint unsigned DIST_SAT = (64'd1 << DIST_FIELD_W) - 1;
  localparam int QUIET_CYCLES = 300;
  localparam int WORD_TARGET  = 420;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     in_kind = 1'b0;
  coord_t                   in_coord_x = '0;
  coord_t                   in_coord_y = '0;
  coord_t                   in_coord_z = '0;
  logic                     in_last_point = 1'b0;
  logic                     out_valid;
  logic [INDEX_FIELD_W-1:0] out_target_index;
  logic [DIST_FIELD_W-1:0]  out_distance_sq;
  logic                     out_end_of_run;
  logic                     out_overflow;
  logic                     cfg_we = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  coord_t           stored_pts [POINT_CAPACITY_DEF][3];
  coord_t           origin_pt [3];
  int               stored_count;
  bit               overflowed;
  logic [CFG_W-1:0] target_setting;
  pick_t            picks_due [$];
  int               errors;
  int               words_sent;
  bit               steady;

  k_nearest_point_select dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_target_index (out_target_index),
    .out_distance_sq  (out_distance_sq),
    .out_end_of_run   (out_end_of_run),
    .out_overflow     (out_overflow),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void queue_pick(int idx, longint unsigned reach, bit end_flag);
    pick_t p;
    p.index    = idx[INDEX_FIELD_W-1:0];
    p.dist_sq  = (reach > DIST_SAT) ? DIST_SAT[DIST_FIELD_W-1:0] : reach[DIST_FIELD_W-1:0];
    p.end_flag = end_flag;
    p.ovf      = overflowed;
    picks_due.push_back(p);
  endfunction

  // Updates the stored set for one accepted word and queues the nearest picks it releases.
  function automatic void model_word(cmd_op_t op, coord_t x, coord_t y, coord_t z,
                                     bit last_mark);
    longint unsigned reach [POINT_CAPACITY_DEF];
    bit              taken [POINT_CAPACITY_DEF];
    longint signed   diff;
    longint unsigned sq;
    longint unsigned total;
    int              want;
    int              best;
    int              i;
    int              a;
    int              n;
    if (op == CMD_ORIGIN) begin
      origin_pt = '{x, y, z};
      return;
    end
    if (stored_count < POINT_CAPACITY_DEF) begin
      stored_pts[stored_count] = '{x, y, z};
      stored_count++;
    end else begin
      overflowed = 1'b1;
    end
    if (!last_mark) return;
    want = (int'(target_setting) < TARGET_LIMIT_DEF) ? int'(target_setting) : TARGET_LIMIT_DEF;
    for (i = 0; i < stored_count; i++) begin
      total = 0;
      for (a = 0; a < 3; a++) begin
        diff = longint'(stored_pts[i][a]) - longint'(origin_pt[a]);
        sq = (diff < 0) ? -diff : diff;
        sq = sq * sq;
        total = (total > ~sq) ? '1 : total + sq;
      end
      reach[i] = total;
      taken[i] = 1'b0;
    end
    if (stored_count <= want) begin
      for (i = 0; i < stored_count; i++) queue_pick(i, reach[i], i == stored_count - 1);
    end else begin
      for (n = 0; n < want; n++) begin
        best = -1;
        for (i = 0; i < stored_count; i++) begin
          if (!taken[i] && (best < 0 || reach[i] < reach[best])) best = i;
        end
        taken[best] = 1'b1;
        queue_pick(best, reach[best], n == want - 1);
      end
    end
    stored_count = 0;
    overflowed   = 1'b0;
  endfunction

  task automatic send_word(input cmd_op_t op, input coord_t x, input coord_t y,
                           input coord_t z, input bit last_mark);
    if (!steady && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start         <= 1'b1;
    in_kind       <= op;
    in_coord_x    <= x;
    in_coord_y    <= y;
    in_coord_z    <= z;
    in_last_point <= last_mark;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_word(op, x, y, z, last_mark);
    words_sent++;
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (picks_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_target_count(input logic [CFG_W-1:0] value);
    cfg_we         <= 1'b1;
    cfg_wdata      <= value;
    target_setting = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int style);
    int v;
    if ($urandom_range(7) == 0) style = 0;
    case (style)
      0: return coord_t'($urandom);
      1: begin
        v = $urandom_range(6);
        return coord_t'(v - 3);
      end
      2: begin
        case ($urandom_range(3))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
      default: begin
        v = $urandom_range(2000);
        return coord_t'(v - 1000);
      end
    endcase
  endfunction

  task automatic test_reset_setting();
    send_word(CMD_POINT, 3, 4, 0, 1'b0);
    send_word(CMD_POINT, 1, 1, 1, 1'b0);
    send_word(CMD_POINT, -2, 0, 0, 1'b1);
    send_word(CMD_POINT, 5, 5, 5, 1'b1);
  endtask

  task automatic test_origin_handling();
    send_word(CMD_ORIGIN, 10, -10, 0, 1'b1);
    send_word(CMD_POINT, 11, -10, 0, 1'b0);
    send_word(CMD_POINT, 10, -10, 0, 1'b0);
    send_word(CMD_ORIGIN, 12, -10, 0, 1'b0);
    send_word(CMD_POINT, 30, 0, 0, 1'b1);
  endtask

  task automatic test_coord_extremes();
    wait_for_quiet();
    write_target_count(5'd16);
    send_word(CMD_ORIGIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_word(CMD_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_word(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_word(CMD_POINT, COORD_MAX, COORD_MIN, 0, 1'b0);
    send_word(CMD_POINT, -1, -1, -1, 1'b1);
  endtask

  task automatic test_tied_distances();
    wait_for_quiet();
    write_target_count(5'd3);
    send_word(CMD_ORIGIN, 0, 0, 0, 1'b0);
    send_word(CMD_POINT, 1, 0, 0, 1'b0);
    send_word(CMD_POINT, 0, 1, 0, 1'b0);
    send_word(CMD_POINT, 0, 0, 1, 1'b0);
    send_word(CMD_POINT, -1, 0, 0, 1'b0);
    send_word(CMD_POINT, 0, 0, 0, 1'b1);
  endtask

  task automatic test_zero_targets();
    wait_for_quiet();
    write_target_count(5'd0);
    send_word(CMD_POINT, 7, 8, 9, 1'b0);
    send_word(CMD_POINT, -7, 8, 9, 1'b0);
    send_word(CMD_POINT, 7, -8, 9, 1'b1);
    wait_for_quiet();
    write_target_count(5'd31);
    send_word(CMD_POINT, 100, 0, 0, 1'b0);
    send_word(CMD_POINT, 1, 0, 0, 1'b1);
  endtask

  // The last point lands beyond capacity and must still start the selection.
  task automatic test_store_overflow();
    int k;
    wait_for_quiet();
    write_target_count(5'd16);
    send_word(CMD_ORIGIN, 0, 0, 0, 1'b0);
    steady = 1'b1;
    for (k = 0; k < POINT_CAPACITY_DEF + 2; k++) begin
      if (k == 100) steady = 1'b0;
      send_word(CMD_POINT, rand_coord(1 + 2 * $urandom_range(1)), rand_coord(1),
                rand_coord(1), k == POINT_CAPACITY_DEF + 1);
    end
    send_word(CMD_POINT, 2, 2, 2, 1'b0);
    send_word(CMD_POINT, 1, 1, 1, 1'b1);
  endtask

  task automatic test_random_sets();
    int style;
    int set_len;
    int k;
    bit first_phase;
    first_phase = 1'b1;
    while (words_sent < WORD_TARGET) begin
      wait_for_quiet();
      case ($urandom_range(5))
        0: write_target_count(5'd0);
        1: write_target_count(5'd31);
        2: write_target_count(5'd16);
        3: write_target_count(5'd1);
        default: write_target_count(CFG_W'($urandom_range(31)));
      endcase
      steady = first_phase;
      first_phase = 1'b0;
      repeat ($urandom_range(4, 1)) begin
        style = $urandom_range(3);
        if ($urandom_range(2) == 0) begin
          send_word(CMD_ORIGIN, rand_coord(style), rand_coord(style), rand_coord(style),
                    $urandom_range(1));
        end
        set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
        for (k = 0; k < set_len; k++) begin
          if ($urandom_range(15) == 0) begin
            send_word(CMD_ORIGIN, rand_coord(style), rand_coord(style), rand_coord(style),
                      $urandom_range(1));
          end
          send_word(CMD_POINT, rand_coord(style), rand_coord(style), rand_coord(style),
                    k == set_len - 1);
        end
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    pick_t want_pick;
    if (rst_n && out_valid) begin
      if (picks_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, target_index %0d distance_sq %0d", $time,
                 out_target_index, out_distance_sq);
      end else begin
        want_pick = picks_due.pop_front();
        if (out_target_index !== want_pick.index) begin
          errors++;
          $display("%0t: target_index expected %0d got %0d", $time, want_pick.index,
                   out_target_index);
        end
        if (out_distance_sq !== want_pick.dist_sq) begin
          errors++;
          $display("%0t: distance_sq expected %0d got %0d", $time, want_pick.dist_sq,
                   out_distance_sq);
        end
        if (out_end_of_run !== want_pick.end_flag) begin
          errors++;
          $display("%0t: end_of_run expected %0b got %0b", $time, want_pick.end_flag,
                   out_end_of_run);
        end
        if (out_overflow !== want_pick.ovf) begin
          errors++;
          $display("%0t: overflow expected %0b got %0b", $time, want_pick.ovf, out_overflow);
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("k_nearest_point_select test failed");
    $finish;
  end

  initial begin
    stored_count   = 0;
    overflowed     = 1'b0;
    origin_pt      = '{0, 0, 0};
    target_setting = 5'd1;
    errors         = 0;
    words_sent     = 0;
    steady         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_setting();
    test_origin_handling();
    test_coord_extremes();
    test_tied_distances();
    test_zero_targets();
    test_store_overflow();
    test_random_sets();
    wait_for_quiet();
    if (errors == 0) begin
      $display("k_nearest_point_select test passed");
    end else begin
      $display("k_nearest_point_select test failed");
    end
    $finish;
  end

endmodule
